// File: sv/nearest_neighbor_tour_search_defines.svh
// ----------------------------------------------------------------------------
// nearest neighbour tour search: assertion macros
// shared assertion forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_TOUR_SEARCH_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_SEARCH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NNTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NNTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nnts_pkg.sv
// ----------------------------------------------------------------------------
// nnts_pkg
// types and fixed constants of the nearest neighbour tour search
// ----------------------------------------------------------------------------
package nnts_pkg;

  // longest walk in edges and the bound on an acceptable tour length
  localparam int unsigned PATH_MAX    = 15;
  localparam int unsigned PATH_SLOT_W = 4;
  localparam int unsigned PATH_DEPTH  = 32;
  localparam logic [19:0] LENGTH_LIMIT = 20'd100000;
  // vertex numbers carried by the item fields
  localparam int unsigned FIELD_VERTS = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_PATH  = 3'd4,
    ST_NONE  = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0]  a;
    logic [3:0]  b;
    logic [15:0] w;
  } edge_t;

  // commands from the sequencer to the edge store
  typedef struct packed {
    logic add;
    logic clear;
    logic rd;
    logic wr;
  } store_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_START,
    S_SORT_KEY,
    S_SORT_CMP,
    S_SORT_PUT,
    S_WALK_START,
    S_WALK_SCAN,
    S_WALK_END,
    S_EMIT_PATH,
    S_EMIT_EDGE,
    S_EMIT_OUT,
    S_EMIT_NONE
  } fsm_t;

endpackage

// File: sv/nearest_neighbor_tour_search.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_search
// add and clear act only in idle; an add's result is registered and offered
// in the next cycle; a run insertion-sorts the table, then walks from each
// start vertex, all bound by the one read port of the edge memory; each path
// edge then passes the path store, the edge memory and the result register
// synchronous reset empties the table and sets the vertex count to 16
// ----------------------------------------------------------------------------
`include "nearest_neighbor_tour_search_defines.svh"

module nearest_neighbor_tour_search import nnts_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  vertex_a,
  input  logic [3:0]  vertex_b,
  input  logic [15:0] weight,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [3:0]  edge_a,
  output logic [3:0]  edge_b,
  output logic [15:0] edge_weight,
  output logic [19:0] total_length,
  output logic        last
);

  localparam int unsigned CW  = ($clog2(MAX_VERTICES+1) > 5) ? $clog2(MAX_VERTICES+1) : 5;
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned SCW = $clog2(MAX_EDGES+1);

  fsm_t state, state_next;

  logic [4:0]     vtx_limit;
  logic [CW-1:0]  active_n;

  // edge store port
  store_cmd_t     cmd;
  logic [AW-1:0]  rd_addr, wr_addr;
  edge_t          wr_data, rd_data;
  logic [SCW-1:0] stored;
  status_t        add_status;

  // sort registers
  logic [SCW-1:0] sort_i, sort_i_next, sort_j, sort_j_next;
  logic [SCW-1:0] i_m1, j_m1, j_m2;
  edge_t          key, key_next;
  logic           shift;

  // walk registers
  logic [CW-1:0]  s, s_next, cur, cur_next;
  logic [15:0]    visited, visited_next;
  logic [19:0]    len, len_next, best_len, best_len_next;
  logic [3:0]     pc, pc_next, best_cnt, best_cnt_next, k, k_next;
  logic [SCW-1:0] j_issue, j_issue_next;
  logic           pend_v, pend_v_next;
  logic [AW-1:0]  pend_j, pend_j_next;
  logic           cur_bank, cur_bank_next, best_bank, best_bank_next;
  logic           issue, in_range, hit_a, hit_b, match, walk_done, k_last;
  logic [CW-1:0]  ea_x, eb_x;

  // path store
  logic [AW-1:0]  path_mem [PATH_DEPTH];
  logic [AW-1:0]  path_rd;
  logic           path_we, path_re;
  logic [PATH_SLOT_W:0] path_raddr;

  // output register
  logic           rv, load_ok, out_load, accept;
  status_t        r_status, o_status;
  logic [3:0]     r_a, r_b, o_a, o_b;
  logic [15:0]    r_w, o_w;
  logic [19:0]    r_total, o_total;
  logic           r_last, o_last;

  // effective vertex count
  always_comb begin
    if (CW'(vtx_limit) > CW'(MAX_VERTICES)) begin
      active_n = CW'(MAX_VERTICES);
    end else begin
      active_n = CW'(vtx_limit);
    end
  end

  // handshakes
  assign cfg_ready  = 1'b1;
  assign load_ok    = !rv || !result_stall;
  assign item_stall = (state != S_IDLE) || !load_ok;
  assign accept     = item_valid && !item_stall;

  // sort helpers
  assign i_m1  = sort_i - SCW'(1);
  assign j_m1  = sort_j - SCW'(1);
  assign j_m2  = sort_j - SCW'(2);
  assign shift = rd_data.w > key.w;

  // walk match on the edge read last cycle
  always_comb begin
    ea_x      = CW'(rd_data.a);
    eb_x      = CW'(rd_data.b);
    issue     = j_issue < stored;
    in_range  = (ea_x < active_n) && (eb_x < active_n);
    hit_a     = (ea_x == cur) && !visited[rd_data.b];
    hit_b     = (eb_x == cur) && !visited[rd_data.a];
    match     = pend_v && in_range && (hit_a || hit_b);
    walk_done = match ? (pc == 4'(PATH_MAX - 1)) : (!pend_v && !issue);
    k_last    = (4'(k + 4'd1) == best_cnt);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && op_t'(op) == OP_RUN) state_next = S_SORT_START;
      end
      S_SORT_START: begin
        state_next = (sort_i < stored) ? S_SORT_KEY : S_WALK_START;
      end
      S_SORT_KEY: state_next = S_SORT_CMP;
      S_SORT_CMP: begin
        if (!shift || sort_j == SCW'(1)) state_next = S_SORT_PUT;
      end
      S_SORT_PUT: state_next = S_SORT_START;
      S_WALK_START: begin
        if (s < active_n) begin
          state_next = S_WALK_SCAN;
        end else begin
          state_next = (best_cnt == '0) ? S_EMIT_NONE : S_EMIT_PATH;
        end
      end
      S_WALK_SCAN: begin
        if (walk_done) state_next = S_WALK_END;
      end
      S_WALK_END:  state_next = S_WALK_START;
      S_EMIT_PATH: state_next = S_EMIT_EDGE;
      S_EMIT_EDGE: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (load_ok) state_next = k_last ? S_IDLE : S_EMIT_PATH;
      end
      S_EMIT_NONE: begin
        if (load_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd            = '0;
    rd_addr        = '0;
    wr_addr        = sort_j[AW-1:0];
    wr_data        = key;
    sort_i_next    = sort_i;
    sort_j_next    = sort_j;
    key_next       = key;
    s_next         = s;
    cur_next       = cur;
    visited_next   = visited;
    len_next       = len;
    pc_next        = pc;
    j_issue_next   = j_issue;
    pend_v_next    = pend_v;
    pend_j_next    = pend_j;
    best_len_next  = best_len;
    best_cnt_next  = best_cnt;
    cur_bank_next  = cur_bank;
    best_bank_next = best_bank;
    k_next         = k;
    path_we        = 1'b0;
    path_re        = 1'b0;
    path_raddr     = {best_bank, k};
    out_load       = 1'b0;
    o_status       = ST_NONE;
    o_a            = '0;
    o_b            = '0;
    o_w            = '0;
    o_total        = best_len;
    o_last         = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_ADD: begin
              cmd.add  = 1'b1;
              out_load = 1'b1;
              o_status = add_status;
              o_total  = '0;
            end
            OP_RUN: begin
              sort_i_next   = SCW'(1);
              best_len_next = LENGTH_LIMIT;
              best_cnt_next = '0;
              s_next        = '0;
            end
            OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      // insertion sort: fetch key, shift heavier entries up, drop key in
      S_SORT_START: begin
        cmd.rd  = sort_i < stored;
        rd_addr = sort_i[AW-1:0];
      end
      S_SORT_KEY: begin
        key_next    = rd_data;
        sort_j_next = sort_i;
        cmd.rd      = 1'b1;
        rd_addr     = i_m1[AW-1:0];
      end
      S_SORT_CMP: begin
        if (shift) begin
          cmd.wr      = 1'b1;
          wr_data     = rd_data;
          sort_j_next = j_m1;
          if (sort_j != SCW'(1)) begin
            cmd.rd  = 1'b1;
            rd_addr = j_m2[AW-1:0];
          end
        end
      end
      S_SORT_PUT: begin
        cmd.wr      = 1'b1;
        sort_i_next = sort_i + SCW'(1);
      end
      S_WALK_START: begin
        cur_next     = s;
        visited_next = (s < CW'(FIELD_VERTS)) ? (16'd1 << s[3:0]) : '0;
        len_next     = '0;
        pc_next      = '0;
        j_issue_next = '0;
        pend_v_next  = 1'b0;
        k_next       = '0;
      end
      // scan the table in order, restart from the top after each step
      S_WALK_SCAN: begin
        cmd.rd  = issue;
        rd_addr = j_issue[AW-1:0];
        if (match) begin
          path_we      = 1'b1;
          len_next     = len + 20'(rd_data.w);
          cur_next     = hit_a ? eb_x : ea_x;
          visited_next = visited | (16'd1 << (hit_a ? rd_data.b : rd_data.a));
          pc_next      = pc + 4'd1;
          j_issue_next = '0;
          pend_v_next  = 1'b0;
        end else if (issue) begin
          j_issue_next = j_issue + SCW'(1);
          pend_v_next  = 1'b1;
          pend_j_next  = j_issue[AW-1:0];
        end else begin
          pend_v_next = 1'b0;
        end
      end
      S_WALK_END: begin
        if (len < best_len) begin
          best_len_next  = len;
          best_cnt_next  = pc;
          best_bank_next = cur_bank;
          cur_bank_next  = !cur_bank;
        end
        s_next = s + CW'(1);
      end
      S_EMIT_PATH: path_re = 1'b1;
      S_EMIT_EDGE: begin
        cmd.rd  = 1'b1;
        rd_addr = path_rd;
      end
      S_EMIT_OUT: begin
        if (load_ok) begin
          out_load = 1'b1;
          o_status = ST_PATH;
          o_a      = rd_data.a;
          o_b      = rd_data.b;
          o_w      = rd_data.w;
          o_last   = k_last;
          k_next   = k + 4'd1;
        end
      end
      S_EMIT_NONE: out_load = load_ok;
      default: ;
    endcase
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vtx_limit <= 5'd16;
      rv        <= 1'b0;
      cur_bank  <= 1'b0;
      best_bank <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) vtx_limit <= cfg_data;
      rv        <= out_load || (rv && result_stall);
      cur_bank  <= cur_bank_next;
      best_bank <= best_bank_next;
    end
    sort_i    <= sort_i_next;
    sort_j    <= sort_j_next;
    key       <= key_next;
    s         <= s_next;
    cur       <= cur_next;
    visited   <= visited_next;
    len       <= len_next;
    pc        <= pc_next;
    j_issue   <= j_issue_next;
    pend_v    <= pend_v_next;
    pend_j    <= pend_j_next;
    best_len  <= best_len_next;
    best_cnt  <= best_cnt_next;
    k         <= k_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      r_status <= o_status;
      r_a      <= o_a;
      r_b      <= o_b;
      r_w      <= o_w;
      r_total  <= o_total;
      r_last   <= o_last;
    end
  end

  // two-bank path store, registered read
  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[{cur_bank, pc}] <= pend_j;
    end
    if (path_re) begin
      path_rd <= path_mem[path_raddr];
    end
  end

  assign result_valid = rv;
  assign status       = r_status;
  assign edge_a       = r_a;
  assign edge_b       = r_b;
  assign edge_weight  = r_w;
  assign total_length = r_total;
  assign last         = r_last;

  nnts_edge_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .active_n   (active_n),
    .add_a      (vertex_a),
    .add_b      (vertex_b),
    .add_w      (weight),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data),
    .stored     (stored),
    .add_status (add_status)
  );

  `NNTS_ASSERT_NEXT(a_run_blocks, accept && op_t'(op) == OP_RUN, item_stall, "item taken during run")
  `NNTS_ASSERT_NOW(a_load_free, out_load, load_ok, "result register overwritten while held")
  `NNTS_ASSERT_NOW(a_path_bound, state == S_WALK_SCAN, pc < 4'(PATH_MAX), "walk beyond path store")
  `NNTS_ASSERT_NOW(a_emit_count, state == S_EMIT_OUT, best_cnt != '0 && k < best_cnt, "emit past path")

endmodule

// File: sv/nnts_edge_store.sv
// ----------------------------------------------------------------------------
// nnts_edge_store
// edge table memory, adjacency flags, fill count and add checking
// ----------------------------------------------------------------------------
`include "nearest_neighbor_tour_search_defines.svh"

module nnts_edge_store import nnts_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  store_cmd_t cmd,
  input  logic [(($clog2(MAX_VERTICES+1) > 5) ? $clog2(MAX_VERTICES+1) : 5)-1:0] active_n,
  input  logic [3:0]  add_a,
  input  logic [3:0]  add_b,
  input  logic [15:0] add_w,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] wr_addr,
  input  edge_t       wr_data,
  output edge_t       rd_data,
  output logic [$clog2(MAX_EDGES+1)-1:0] stored,
  output status_t     add_status
);

  localparam int unsigned CW  = ($clog2(MAX_VERTICES+1) > 5) ? $clog2(MAX_VERTICES+1) : 5;
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned SCW = $clog2(MAX_EDGES+1);
  localparam int unsigned VN  = (MAX_VERTICES < FIELD_VERTS) ? MAX_VERTICES : FIELD_VERTS;
  localparam int unsigned VNW = $clog2(VN);

  edge_t          mem [MAX_EDGES];
  logic [VN-1:0]  adj [VN];
  logic           add_ok;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  edge_t          mem_wdata;

  // add checks: range, then duplicate, then full
  always_comb begin
    if (CW'(add_a) >= active_n || CW'(add_b) >= active_n) begin
      add_status = ST_RANGE;
    end else if (adj[add_a[VNW-1:0]][add_b[VNW-1:0]]) begin
      add_status = ST_DUP;
    end else if (stored >= SCW'(MAX_EDGES)) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_ADDED;
    end
  end

  assign add_ok = cmd.add && (add_status == ST_ADDED);

  // one write port shared by appends and sort moves
  always_comb begin
    mem_we    = cmd.wr || add_ok;
    mem_waddr = cmd.wr ? wr_addr : stored[AW-1:0];
    mem_wdata = cmd.wr ? wr_data : edge_t'{a: add_a, b: add_b, w: add_w};
  end

  // fill count and adjacency flags
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      stored <= '0;
      for (int r = 0; r < VN; r++) begin
        adj[r] <= '0;
      end
    end else if (add_ok) begin
      stored <= stored + SCW'(1);
      adj[add_a[VNW-1:0]][add_b[VNW-1:0]] <= 1'b1;
      adj[add_b[VNW-1:0]][add_a[VNW-1:0]] <= 1'b1;
    end
  end

  // edge table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  `NNTS_ASSERT_NOW(a_stored_bound, 1'b1, stored <= SCW'(MAX_EDGES), "edge count beyond table")
  `NNTS_ASSERT_NEXT(a_clear_empties, cmd.clear, stored == '0, "clear left edges behind")
  `NNTS_ASSERT_NOW(a_one_writer, cmd.wr, !cmd.add, "sort move collides with append")

endmodule
